// ===== sv/rbma_pkg.sv =====
// Package: shared widths, defaults and the cell shift control type.
package rbma_pkg;

  localparam int RBMA_DEPTH = 16;
  localparam int SAMPLE_W   = 16;
  localparam int WIN_W      = 5;
  localparam int FILL_W     = 5;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;

  // Shift control handed to every cell of the sample chain
  typedef struct packed {
    logic push;  // move toward the old end, new sample enters cell 0
    logic rot;   // move toward cell 0, cell 0 wraps to the old end
  } rbma_shift_t;

endpackage

// ===== sv/rbma_ifs.sv =====
// Interfaces: sample input channel and average output channel.
interface rbma_in_if
  import rbma_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rbma_out_if
  import rbma_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] average;
  logic        [FILL_W-1:0]   fill_count;

  modport source (output valid, output average, output fill_count, input ready);
  modport sink (input valid, input average, input fill_count, output ready);
endinterface

// ===== sv/rbma_cell.sv =====
// Cell: one sample slot of the store, shifts to either neighbor.
module rbma_cell
  import rbma_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  rbma_shift_t                ctl,
  input  logic signed [SAMPLE_W-1:0] from_lower,
  input  logic signed [SAMPLE_W-1:0] from_upper,
  output logic signed [SAMPLE_W-1:0] value
);

  // Take the lower neighbor on a push, the upper one on a rotate
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctl.push) begin
      value <= from_lower;
    end else if (ctl.rot) begin
      value <= from_upper;
    end
  end

endmodule

// ===== sv/rbma_div.sv =====
// Divider: serial restoring divide of a signed sum by the window length.
module rbma_div
  import rbma_pkg::*;
#(
  parameter int SW = 21,
  parameter int WW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SW-1:0] dividend,
  input  logic        [WW-1:0] divisor,
  output logic                 done,
  output logic signed [SW-1:0] quot
);

  localparam int CNT_W = $clog2(SW + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic [SW-1:0]    q;
  logic [WW-1:0]    rem;
  logic [WW:0]      rem_sh;
  logic [WW:0]      diff;
  logic             ge;
  logic [SW-1:0]    q_next;

  // One quotient bit per cycle
  always_comb begin
    rem_sh = {rem, q[SW-1]};
    diff   = rem_sh - {1'b0, divisor};
    ge     = (rem_sh >= {1'b0, divisor});
    q_next = {q[SW-2:0], ge};
  end

  // Load magnitude on start, iterate, apply the sign at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SW);
        neg  <= dividend[SW-1];
        q    <= dividend[SW-1] ? -dividend : dividend;
        rem  <= '0;
      end else if (busy) begin
        q   <= q_next;
        rem <= ge ? diff[WW-1:0] : rem_sh[WW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          quot <= neg ? -q_next : q_next;
        end
      end
    end
  end

endmodule

// ===== sv/ring_buffer_moving_average.sv =====
// Top level: moving average over a chain of sample cells.
//
//   channel    direction  payload                       handshake
//   in_ch      sink       sample                        valid / ready
//   out_ch     source     average, fill_count           valid / ready
//   cfg        write      window_len (cfg_we, cfg_data) write on cfg_we
//
// One sample at a time: the block takes no new sample until the last result has been handed off.
// The sum walks the cell chain once around; the serial divider then yields
// one quotient bit per cycle over the SW = 16 + clog2(DEPTH) + 1 sum bits.
// Reset clears all cells, the slot count and the window to 16.
// A finished result waits in the divider while a stalled sink holds the output
// register; the block takes the next sample once the result has moved there.
module ring_buffer_moving_average
  import rbma_pkg::*;
#(
  parameter int DEPTH = RBMA_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  rbma_in_if.sink          in_ch,
  rbma_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_data
);

  localparam int WW    = $clog2(DEPTH + 1);
  localparam int CW    = (WW > WIN_W) ? WW : WIN_W;
  localparam int SW    = SAMPLE_W + $clog2(DEPTH) + 1;
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                     state;
  logic [WIN_W-1:0]           window_len;
  logic [WW-1:0]              filled;
  logic [IDX_W-1:0]           cnt;
  logic signed [SW-1:0]       acc;
  logic signed [SAMPLE_W-1:0] cell_val [DEPTH];
  rbma_shift_t                shift;
  logic [CW-1:0]              wl_ext;
  logic [WW-1:0]              weff;
  logic                       in_beat;
  logic                       div_done;
  logic signed [SW-1:0]       quot;

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_RESET;
    end else if (cfg_we) begin
      window_len <= cfg_data;
    end
  end

  // Clamp window to 1 .. DEPTH
  always_comb begin
    wl_ext = CW'(window_len);
    if (wl_ext == '0) begin
      weff = WW'(1);
    end else if (wl_ext > CW'(DEPTH)) begin
      weff = WW'(DEPTH);
    end else begin
      weff = WW'(wl_ext);
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign shift.push  = in_beat;
  assign shift.rot   = (state == S_SUM);

  // Sample chain: cell 0 holds the newest sample
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] lower;
    logic signed [SAMPLE_W-1:0] upper;
    if (i == 0) begin : g_head
      assign lower = in_ch.sample;
    end else begin : g_mid_lo
      assign lower = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign upper = cell_val[0];
    end else begin : g_mid_hi
      assign upper = cell_val[i+1];
    end
    rbma_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (shift),
      .from_lower (lower),
      .from_upper (upper),
      .value      (cell_val[i])
    );
  end

  rbma_div #(
    .SW (SW),
    .WW (WW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (acc),
    .divisor  (weff),
    .done     (div_done),
    .quot     (quot)
  );

  // Sequencer: push, walk the ring, divide, hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      filled <= '0;
      cnt    <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // Raise valid on hand-off, drop it once the sink takes the beat
      if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (filled != WW'(DEPTH)) begin
              filled <= filled + 1'b1;
            end
            cnt   <= '0;
            acc   <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // accumulate the newest weff entries as they pass cell 0
          if (WW'(cnt) < weff) begin
            acc <= acc + SW'(cell_val[0]);
          end
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(DEPTH - 1)) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.average    <= quot[SAMPLE_W-1:0];
            out_ch.fill_count <= FILL_W'(filled);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/rbma_checker.sv =====
// Checker: predicts each windowed average and compares it with the output channel.
`timescale 1ns / 100ps

module rbma_checker
  import rbma_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rbma_in_if               in_ch,
  rbma_out_if              out_ch,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_data,
  output int               pending,
  output int               fail_count
);

  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    logic        [FILL_W-1:0]   fill_count;
  } avg_beat_t;

  // Shadow copy of the filter state
  logic signed [SAMPLE_W-1:0] taps [RBMA_DEPTH];
  int                         head;
  int                         filled;
  logic        [WIN_W-1:0]    win_len;

  avg_beat_t pending_avgs [$];

  // Print one line per mismatch and count it
  task automatic report(input string msg);
    $display("%0t checker: %s", $time, msg);
    fail_count++;
  endtask

  // Push a sample into the shadow ring and work out the average it produces
  function automatic avg_beat_t push_and_average(input logic signed [SAMPLE_W-1:0] s);
    avg_beat_t r;
    int        w;
    int        sum;
    int        q;
    head = (head == RBMA_DEPTH - 1) ? 0 : head + 1;
    taps[head] = s;
    if (filled < RBMA_DEPTH) filled++;
    // A zero window acts as one, an oversized window is clamped to the ring
    w = (win_len == '0) ? 1 : ((int'(win_len) > RBMA_DEPTH) ? RBMA_DEPTH : int'(win_len));
    sum = 0;
    for (int i = 0; i < w; i++) begin
      sum += int'(taps[(head + RBMA_DEPTH - i) % RBMA_DEPTH]);
    end
    q = sum / w;
    r.average    = q[SAMPLE_W-1:0];
    r.fill_count = filled[FILL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    avg_beat_t exp_b;
    if (rst) begin
      for (int i = 0; i < RBMA_DEPTH; i++) taps[i] = '0;
      head    = 0;
      filled  = 0;
      win_len = WIN_RESET;
      pending_avgs.delete();
    end else begin
      // Retire the oldest expectation against an accepted output beat
      if (out_ch.valid && out_ch.ready) begin
        if (pending_avgs.size() == 0) begin
          report($sformatf("unexpected beat average=%0d fill=%0d",
                           out_ch.average, out_ch.fill_count));
        end else begin
          exp_b = pending_avgs.pop_front();
          if (out_ch.average !== exp_b.average)
            report($sformatf("average got %0d want %0d", out_ch.average, exp_b.average));
          if (out_ch.fill_count !== exp_b.fill_count)
            report($sformatf("fill_count got %0d want %0d",
                             out_ch.fill_count, exp_b.fill_count));
        end
      end
      // Predict the result of an accepted input beat
      if (in_ch.valid && in_ch.ready) pending_avgs.push_back(push_and_average(in_ch.sample));
      if (cfg_we) win_len = cfg_data;
    end
    pending = pending_avgs.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives samples and window settings, gives the verdict.
`timescale 1ns / 100ps

module tb;
  import rbma_pkg::*;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_data;
  int               pending;
  int               fail_count;
  int               src_idle_pct;
  int               snk_idle_pct;

  rbma_in_if  in_ch ();
  rbma_out_if out_ch ();

  ring_buffer_moving_average dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  rbma_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the output side at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  // Offer one sample beat, with random gaps ahead of it
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the input until every outstanding average has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'sh7FFF;
      1:       v = 16'sh8000;
      2, 3:    v = SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  logic signed [SAMPLE_W-1:0] opening [20] = '{
    16'shFFFF, 16'sh0001, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000,
    16'shFFFD, 16'sh0007, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'shFFFF
  };

  // Window per phase: unit, full, zero, all ones, just past the ring, then mid values
  logic [WIN_W-1:0] win_plan [9] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd5, 5'd15
  };

  initial begin
    logic signed [SAMPLE_W-1:0] run_val;
    int                         run_left;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    src_idle_pct = 16;
    snk_idle_pct = 80;
    run_left     = 0;
    run_val      = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, truncation of negative sums, unwritten slots, fill saturation
    foreach (opening[i]) push_sample(opening[i]);

    // Random phases, each with its own window
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 80;
        snk_idle_pct = 16;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      drain();
      write_window((ph < 9) ? win_plan[ph] : WIN_W'($urandom_range(0, 31)));
      for (int n = 0; n < 190; n++) begin
        // Mostly fresh values, sometimes runs of one value so the window fills evenly
        if (run_left == 0 && $urandom_range(0, 19) == 0) begin
          run_left = $urandom_range(4, 20);
          run_val  = pick_sample();
        end
        if (run_left != 0) begin
          push_sample(run_val);
          run_left--;
        end else begin
          push_sample(pick_sample());
        end
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
